[rtl/qcet_pkg.sv]
// ----------------------------------------------------------------------------
// qcet_pkg
// Shared types and constants for the quad corner extremes tracker.
// ----------------------------------------------------------------------------
package qcet_pkg;

    localparam int PIXEL_W   = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W     = 10;

    localparam logic [PIXEL_W-1:0] FOREGROUND = 8'hFF;
    localparam logic [CFG_W-1:0]   SIZE_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [OUT_W-1:0] coord_t;

    typedef struct packed {
        coord_t upper_left_x;
        coord_t upper_left_y;
        coord_t upper_right_x;
        coord_t upper_right_y;
        coord_t lower_left_x;
        coord_t lower_left_y;
        coord_t lower_right_x;
        coord_t lower_right_y;
    } corners_t;

    // control from the pixel front end to the corner tracker
    typedef struct packed {
        logic step;        // one pixel consumed this cycle
        logic foreground;  // that pixel is foreground
        logic frame_end;   // that pixel closes the frame
        logic restart;     // size register rewritten, drop the frame
    } trk_ctrl_t;

endpackage

[rtl/qcet_tracker.sv]
// ----------------------------------------------------------------------------
// qcet_tracker
// Keeps the four corner extremes of the current frame and presents the
// corner set including the pixel being consumed.
// ----------------------------------------------------------------------------
module qcet_tracker #(
    parameter int CW = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qcet_pkg::trk_ctrl_t ctrl,
    input  logic [CW-1:0]       x,
    input  logic [CW-1:0]       y,
    output qcet_pkg::corners_t  corners
);

    logic                 seen_reg;
    logic [CW:0]          least_sum_reg, least_sum_next;
    logic [CW:0]          greatest_sum_reg, greatest_sum_next;
    logic signed [CW:0]   least_diff_reg, least_diff_next;
    logic signed [CW:0]   greatest_diff_reg, greatest_diff_next;
    logic [CW-1:0]        coord_reg  [8];
    logic [CW-1:0]        coord_next [8];

    logic [CW:0]          sum;
    logic signed [CW:0]   diff;
    logic                 hit;
    logic                 upd_ul, upd_ur, upd_ll, upd_lr;

    assign sum  = {1'b0, x} + {1'b0, y};
    assign diff = $signed({1'b0, x}) - $signed({1'b0, y});
    assign hit  = ctrl.step && ctrl.foreground;

    // first foreground pixel of a frame always takes every corner
    assign upd_ul = hit && (!seen_reg || (sum < least_sum_reg));
    assign upd_ur = hit && (!seen_reg || (diff > greatest_diff_reg));
    assign upd_ll = hit && (!seen_reg || (diff < least_diff_reg));
    assign upd_lr = hit && (!seen_reg || (sum >= greatest_sum_reg));

    always_comb
    begin
        coord_next         = coord_reg;
        least_sum_next     = least_sum_reg;
        greatest_sum_next  = greatest_sum_reg;
        least_diff_next    = least_diff_reg;
        greatest_diff_next = greatest_diff_reg;
        if (upd_ul)
        begin
            least_sum_next = sum;
            coord_next[0]  = x;
            coord_next[1]  = y;
        end
        if (upd_ur)
        begin
            greatest_diff_next = diff;
            coord_next[2]      = x;
            coord_next[3]      = y;
        end
        if (upd_ll)
        begin
            least_diff_next = diff;
            coord_next[4]   = x;
            coord_next[5]   = y;
        end
        if (upd_lr)
        begin
            greatest_sum_next = sum;
            coord_next[6]     = x;
            coord_next[7]     = y;
        end
    end

    assign corners.upper_left_x  = qcet_pkg::OUT_W'(coord_next[0]);
    assign corners.upper_left_y  = qcet_pkg::OUT_W'(coord_next[1]);
    assign corners.upper_right_x = qcet_pkg::OUT_W'(coord_next[2]);
    assign corners.upper_right_y = qcet_pkg::OUT_W'(coord_next[3]);
    assign corners.lower_left_x  = qcet_pkg::OUT_W'(coord_next[4]);
    assign corners.lower_left_y  = qcet_pkg::OUT_W'(coord_next[5]);
    assign corners.lower_right_x = qcet_pkg::OUT_W'(coord_next[6]);
    assign corners.lower_right_y = qcet_pkg::OUT_W'(coord_next[7]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (ctrl.restart || (ctrl.step && ctrl.frame_end))
        begin
            seen_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (ctrl.step)
        begin
            seen_reg  <= seen_reg || hit;
            coord_reg <= coord_next;
        end
    end

    // extremes are only meaningful once seen_reg is set
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            least_sum_reg     <= least_sum_next;
            greatest_sum_reg  <= greatest_sum_next;
            least_diff_reg    <= least_diff_next;
            greatest_diff_reg <= greatest_diff_next;
        end
    end

endmodule

[rtl/quad_corner_extremes_tracker_top.sv]
// ----------------------------------------------------------------------------
// quad_corner_extremes_tracker_top
// Raster pixel stream in, four foreground corner coordinates out per frame.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock. Column and row are counted internally from
// image_width and image_height (0 reads as 1, above MAX_DIMENSION clamps).
// A pixel of 255 is foreground. After the last pixel of a frame one result
// carries the eight corner coordinates (all zero if the frame held no
// foreground) from the output register. Input register, one
// compare-and-update stage, output register: the output register only holds
// back the input when a finished result is still stalled and the next frame
// end arrives. Writing either size register restarts the frame; writes are
// only meant while no pixel is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module quad_corner_extremes_tracker_top #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pixel channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [qcet_pkg::PIXEL_W-1:0]          pixel_value,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [qcet_pkg::OUT_W-1:0]            upper_left_x,
    output logic [qcet_pkg::OUT_W-1:0]            upper_left_y,
    output logic [qcet_pkg::OUT_W-1:0]            upper_right_x,
    output logic [qcet_pkg::OUT_W-1:0]            upper_right_y,
    output logic [qcet_pkg::OUT_W-1:0]            lower_left_x,
    output logic [qcet_pkg::OUT_W-1:0]            lower_left_y,
    output logic [qcet_pkg::OUT_W-1:0]            lower_right_x,
    output logic [qcet_pkg::OUT_W-1:0]            lower_right_y,
    // configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qcet_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qcet_pkg::CFG_W-1:0]            cfg_data
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int EW = (CW + 1 > qcet_pkg::CFG_W) ? CW + 1 : qcet_pkg::CFG_W;
    localparam logic [EW-1:0] MAX_SIZE = EW'(MAX_DIMENSION);

    logic [qcet_pkg::CFG_W-1:0]   width_reg, height_reg;
    logic [EW-1:0]                eff_w, eff_h;
    logic                         cfg_write;
    logic                         restart;

    logic [CW-1:0]                col_reg, row_reg;
    logic                         col_last, row_last;
    logic                         in_take;

    logic                         s1_valid_reg;
    logic [qcet_pkg::PIXEL_W-1:0] s1_pixel_reg;
    logic [CW-1:0]                s1_x_reg, s1_y_reg;
    logic                         s1_last_reg;
    logic                         s1_go;

    logic                         out_valid_reg;
    qcet_pkg::corners_t           out_reg;
    qcet_pkg::corners_t           corners;
    qcet_pkg::trk_ctrl_t          trk_ctrl;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            case (qcet_pkg::cfg_reg_t'(cfg_index))
                qcet_pkg::REG_IMAGE_WIDTH:  restart = 1'b1;
                qcet_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
                default:                    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= qcet_pkg::SIZE_RESET;
            height_reg <= qcet_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (qcet_pkg::cfg_reg_t'(cfg_index))
                qcet_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                qcet_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            eff_w = EW'(1);
        else if (EW'(width_reg) > MAX_SIZE)
            eff_w = MAX_SIZE;
        else
            eff_w = EW'(width_reg);

        if (height_reg == '0)
            eff_h = EW'(1);
        else if (EW'(height_reg) > MAX_SIZE)
            eff_h = MAX_SIZE;
        else
            eff_h = EW'(height_reg);
    end

    // ---------------- raster counters ----------------
    assign in_take  = in_valid && !in_stall;
    assign col_last = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign row_last = (EW'(row_reg) + EW'(1)) >= eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_take)
        begin
            if (!col_last)
                col_reg <= col_reg + CW'(1);
            else
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + CW'(1);
            end
        end
    end

    // ---------------- input register ----------------
    // a frame-end pixel waits here while the previous result is still stalled
    assign s1_go    = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pixel_reg <= pixel_value;
            s1_x_reg     <= col_reg;
            s1_y_reg     <= row_reg;
            s1_last_reg  <= col_last && row_last;
        end
    end

    // ---------------- corner tracking ----------------
    assign trk_ctrl.step       = s1_go;
    assign trk_ctrl.foreground = (s1_pixel_reg == qcet_pkg::FOREGROUND);
    assign trk_ctrl.frame_end  = s1_last_reg;
    assign trk_ctrl.restart    = restart;

    qcet_tracker #(
        .CW (CW)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (trk_ctrl),
        .x       (s1_x_reg),
        .y       (s1_y_reg),
        .corners (corners)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
            out_reg <= corners;
    end

    assign out_valid     = out_valid_reg;
    assign upper_left_x  = out_reg.upper_left_x;
    assign upper_left_y  = out_reg.upper_left_y;
    assign upper_right_x = out_reg.upper_right_x;
    assign upper_right_y = out_reg.upper_right_y;
    assign lower_left_x  = out_reg.lower_left_x;
    assign lower_left_y  = out_reg.lower_left_y;
    assign lower_right_x = out_reg.lower_right_x;
    assign lower_right_y = out_reg.lower_right_y;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad corner extremes tracker.
// ----------------------------------------------------------------------------
// Pixel requests are queued by the stimulus process and presented by a
// clocked driver with random gaps. The result side stalls at random. Every
// accepted pixel is run through a local corner predictor, and every finished
// frame leaves one expected corner set behind. Each result is checked field
// by field against the oldest one. Size registers are only rewritten while
// the pipeline is empty. A short directed part covers reset size, zero
// sizes, an empty frame and tie-breaking. Then come random frames of mostly
// small sizes, with some frames cut short by a register write.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int RANDOM_PIXELS = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int MAX_DIM       = 1024;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [qcet_pkg::PIXEL_W-1:0]   pixel_value = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    qcet_pkg::coord_t               upper_left_x;
    qcet_pkg::coord_t               upper_left_y;
    qcet_pkg::coord_t               upper_right_x;
    qcet_pkg::coord_t               upper_right_y;
    qcet_pkg::coord_t               lower_left_x;
    qcet_pkg::coord_t               lower_left_y;
    qcet_pkg::coord_t               lower_right_x;
    qcet_pkg::coord_t               lower_right_y;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [qcet_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [qcet_pkg::CFG_W-1:0]     cfg_data    = '0;

    quad_corner_extremes_tracker_top #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .*
    );

    // predictor state
    logic [qcet_pkg::CFG_W-1:0] width_reg;
    logic [qcet_pkg::CFG_W-1:0] height_reg;
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                least_sum;
    int unsigned                greatest_sum;
    int                         least_diff;
    int                         greatest_diff;
    qcet_pkg::corners_t         corners;

    qcet_pkg::corners_t           pending_corners[$];
    logic [qcet_pkg::PIXEL_W-1:0] pending_pixels[$];

    int fail_count  = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int calm_left   = 0;
    int stall_left  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(logic [qcet_pkg::CFG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_DIM)
            return MAX_DIM;
        return 32'(r);
    endfunction

    task automatic start_frame();
        int unsigned w;
        int unsigned h;
        int unsigned big;
        w             = clamp_size(width_reg);
        h             = clamp_size(height_reg);
        big           = (w > h) ? w : h;
        col_pos       = 0;
        row_pos       = 0;
        least_sum     = w + h;
        greatest_sum  = 0;
        least_diff    = int'(big);
        greatest_diff = -int'(big);
        corners       = '0;
    endtask

    task automatic track_pixel(logic [qcet_pkg::PIXEL_W-1:0] p);
        int unsigned sum;
        int          diff;
        if (p == qcet_pkg::FOREGROUND)
        begin
            sum  = col_pos + row_pos;
            diff = int'(col_pos) - int'(row_pos);
            if (sum < least_sum)
            begin
                least_sum            = sum;
                corners.upper_left_x = qcet_pkg::coord_t'(col_pos);
                corners.upper_left_y = qcet_pkg::coord_t'(row_pos);
            end
            if (diff > greatest_diff)
            begin
                greatest_diff         = diff;
                corners.upper_right_x = qcet_pkg::coord_t'(col_pos);
                corners.upper_right_y = qcet_pkg::coord_t'(row_pos);
            end
            if (diff < least_diff)
            begin
                least_diff           = diff;
                corners.lower_left_x = qcet_pkg::coord_t'(col_pos);
                corners.lower_left_y = qcet_pkg::coord_t'(row_pos);
            end
            // ties replace: last pixel on the far diagonal wins
            if (sum >= greatest_sum)
            begin
                greatest_sum          = sum;
                corners.lower_right_x = qcet_pkg::coord_t'(col_pos);
                corners.lower_right_y = qcet_pkg::coord_t'(row_pos);
            end
        end
        if (col_pos + 1 < clamp_size(width_reg))
            col_pos++;
        else
        begin
            col_pos = 0;
            if (row_pos + 1 < clamp_size(height_reg))
                row_pos++;
            else
            begin
                pending_corners.push_back(corners);
                start_frame();
            end
        end
    endtask

    task automatic check_coord(string name, qcet_pkg::coord_t want, qcet_pkg::coord_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    function automatic int draw_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 25);
    endfunction

    // pixel driver: valid held until taken, next request or a gap follows
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                gap_left = draw_gap();
                if (gap_left == 0 && pending_pixels.size() != 0)
                    pixel_value <= pending_pixels.pop_front();
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_pixels.size() != 0)
                begin
                    in_valid    <= 1'b1;
                    pixel_value <= pending_pixels.pop_front();
                end
            end
        end
    end

    // result-side back-pressure
    always @(posedge clk)
    begin : stall_gen
        int r;
        if (rst_n)
        begin
            if (stall_left > 0)
                stall_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_stall  <= 1'b0;
                    stall_left = $urandom_range(1, 30);
                end
                else if (r < 85)
                begin
                    out_stall  <= 1'b1;
                    stall_left = $urandom_range(1, 3);
                end
                else if (r < 97)
                begin
                    out_stall  <= 1'b1;
                    stall_left = $urandom_range(4, 10);
                end
                else
                begin
                    out_stall  <= 1'b1;
                    stall_left = $urandom_range(20, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        qcet_pkg::corners_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_corners.size() == 0)
                begin
                    $error("corner result with no frame outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_corners.pop_front();
                    check_coord("upper_left_x", want.upper_left_x, upper_left_x);
                    check_coord("upper_left_y", want.upper_left_y, upper_left_y);
                    check_coord("upper_right_x", want.upper_right_x, upper_right_x);
                    check_coord("upper_right_y", want.upper_right_y, upper_right_y);
                    check_coord("lower_left_x", want.lower_left_x, lower_left_x);
                    check_coord("lower_left_y", want.lower_left_y, lower_left_y);
                    check_coord("lower_right_x", want.lower_right_x, lower_right_x);
                    check_coord("lower_right_y", want.lower_right_y, lower_right_y);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qcet_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                start_frame();
            end
            if (in_valid && !in_stall)
                track_pixel(pixel_value);
        end
    end

    function automatic logic [qcet_pkg::PIXEL_W-1:0] rand_pixel(int density);
        if ($urandom_range(0, 99) < density)
            return qcet_pkg::FOREGROUND;
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFE;
            default: return qcet_pkg::PIXEL_W'($urandom_range(0, 254));
        endcase
    endfunction

    function automatic logic [qcet_pkg::CFG_W-1:0] draw_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 94)
            return qcet_pkg::CFG_W'($urandom_range(1, 8));
        return qcet_pkg::CFG_W'($urandom_range(9, 32));
    endfunction

    function automatic int draw_density();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 5;
            2:       return 30;
            3:       return 70;
            4:       return 100;
            default: return $urandom_range(1, 99);
        endcase
    endfunction

    task automatic push_pixels(int unsigned count, int density);
        @(negedge clk);
        repeat (count)
            pending_pixels.push_back(rand_pixel(density));
    endtask

    // everything sent, every result back, then a settling wait for the pipeline
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || pending_corners.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(qcet_pkg::cfg_reg_t idx, logic [qcet_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [qcet_pkg::PIXEL_W-1:0] tie_frame[6];
        logic [qcet_pkg::CFG_W-1:0]   cur_w;
        logic [qcet_pkg::CFG_W-1:0]   cur_h;
        int unsigned                  area;
        int unsigned                  random_count;
        int                           frames;
        int                           r;
        int                           drain;

        tie_frame = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        width_reg  = qcet_pkg::SIZE_RESET;
        height_reg = qcet_pkg::SIZE_RESET;
        start_frame();

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size: a few pixels, then the frame is dropped by the write
        @(negedge clk);
        pending_pixels = '{8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80};
        wait_idle();

        // zero sizes act as a single pixel frame
        write_reg(qcet_pkg::REG_IMAGE_WIDTH, '0);
        write_reg(qcet_pkg::REG_IMAGE_HEIGHT, '0);
        @(negedge clk);
        pending_pixels = '{8'hFF, 8'h00, 8'hFF};
        wait_idle();

        // 3x2: empty frame, then diagonal ties
        write_reg(qcet_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_reg(qcet_pkg::REG_IMAGE_HEIGHT, 11'd2);
        push_pixels(6, 0);
        foreach (tie_frame[i])
            pending_pixels.push_back(tie_frame[i]);
        wait_idle();

        cur_w        = 11'd3;
        cur_h        = 11'd2;
        random_count = 0;
        while (random_count < RANDOM_PIXELS)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                cur_w = draw_size();
                write_reg(qcet_pkg::REG_IMAGE_WIDTH, cur_w);
            end
            else if (r < 30)
            begin
                cur_h = draw_size();
                write_reg(qcet_pkg::REG_IMAGE_HEIGHT, cur_h);
            end
            else
            begin
                cur_w = draw_size();
                cur_h = draw_size();
                if (r < 65)
                begin
                    write_reg(qcet_pkg::REG_IMAGE_WIDTH, cur_w);
                    write_reg(qcet_pkg::REG_IMAGE_HEIGHT, cur_h);
                end
                else
                begin
                    write_reg(qcet_pkg::REG_IMAGE_HEIGHT, cur_h);
                    write_reg(qcet_pkg::REG_IMAGE_WIDTH, cur_w);
                end
            end
            area   = clamp_size(cur_w) * clamp_size(cur_h);
            frames = (area > 64) ? 1 : $urandom_range(1, 4);
            repeat (frames)
            begin
                push_pixels(area, draw_density());
                random_count += area;
            end
            // now and then leave a frame unfinished for the next write to drop
            if (area > 1 && $urandom_range(0, 4) == 0)
                push_pixels($urandom_range(1, area - 1), draw_density());
            wait_idle();
        end

        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid);
        drain = 0;
        while (pending_corners.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (pending_corners.size() != 0)
        begin
            $error("%0d corner results never arrived", pending_corners.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
